### design/cluster_run_list_decoder_top_defines.svh
// Assertion macros for the cluster run list decoder checker.
// Used by crld_checker.sv; needs a clock i_clk and reset i_rst_n in scope.
`ifndef CLUSTER_RUN_LIST_DECODER_TOP_DEFINES_SVH
`define CLUSTER_RUN_LIST_DECODER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CRLD_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("crld assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define CRLD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("crld assertion failed");

`endif

### design/crld_pkg.sv
// Shared types and constants for the cluster run list decoder.
// No dependencies; imported by every module of the block.
`default_nettype none

package crld_pkg;

    localparam int CRLD_Q_DEPTH = 4;
    localparam logic [3:0] CRLD_MAX_FIELD_BYTES = 4'd8;

    // Result codes; the front uses the first four for its events.
    typedef enum logic [2:0] {
        KIND_RUN         = 3'd0,
        KIND_END_OK      = 3'd1,
        KIND_BAD_HEADER  = 3'd2,
        KIND_NEG_LENGTH  = 3'd3,
        KIND_NEG_CLUSTER = 3'd4,
        KIND_LIMIT       = 3'd5
    } t_kind;

    // One parsed event handed from front to back.
    typedef struct packed {
        logic        start;   // event belongs to a list opened by a start byte
        t_kind       kind;
        logic [63:0] len;
        logic [63:0] len_m1;
        logic [63:0] off;
    } t_evt;

endpackage

`default_nettype wire

### design/crld_front.sv
// Byte parser: tracks header/length/offset phases and emits run and status events.
// Depends on crld_pkg.
`default_nettype none

module crld_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  logic            i_list_start,
    input  logic [7:0]      i_data_byte,
    input  logic            i_q_full,
    output logic            o_push,
    output crld_pkg::t_evt  o_evt
);
    import crld_pkg::*;

    typedef enum logic [1:0] {PH_IDLE, PH_HEADER, PH_LENGTH, PH_OFFSET} t_phase;

    t_phase      r_phase, n_phase, phase;
    logic [3:0]  r_lleft, n_lleft, r_oleft, n_oleft;
    logic [2:0]  r_pos, n_pos;
    logic [63:0] r_len, n_len, r_off, n_off;
    logic        r_start, n_start;
    logic [63:0] byte_sh, len_new, off_new;
    logic [3:0]  nl, no, lleft_dec, oleft_dec;
    logic        accept;

    assign accept     = i_in_valid && !i_q_full;
    assign o_in_stall = i_q_full;
    assign phase      = i_list_start ? PH_HEADER : r_phase;
    assign nl         = i_data_byte[3:0];
    assign no         = i_data_byte[7:4];
    assign lleft_dec  = r_lleft - 4'd1;
    assign oleft_dec  = r_oleft - 4'd1;
    assign byte_sh    = 64'(i_data_byte) << {r_pos, 3'b000};

    always_comb begin
        n_phase    = r_phase;
        n_lleft    = r_lleft;
        n_oleft    = r_oleft;
        n_pos      = r_pos;
        n_len      = r_len;
        n_off      = r_off;
        n_start    = r_start;
        len_new    = r_len | byte_sh;
        off_new    = r_off | byte_sh;
        o_push     = 1'b0;
        // a start byte that pushes nothing tags the next event of its list
        o_evt.start = i_list_start || r_start;
        o_evt.kind  = KIND_RUN;
        o_evt.len   = r_len;
        o_evt.off   = r_off;
        if (accept) begin
            n_start = i_list_start || r_start;
            unique case (phase)
                PH_HEADER: begin
                    if (i_data_byte == 8'd0) begin
                        o_push     = 1'b1;
                        o_evt.kind = KIND_END_OK;
                        n_phase    = PH_IDLE;
                    end else if (nl > CRLD_MAX_FIELD_BYTES || no > CRLD_MAX_FIELD_BYTES) begin
                        o_push     = 1'b1;
                        o_evt.kind = KIND_BAD_HEADER;
                        n_phase    = PH_IDLE;
                    end else begin
                        n_lleft = nl;
                        n_oleft = no;
                        n_pos   = 3'd0;
                        n_len   = 64'd0;
                        n_off   = 64'd0;
                        if (nl != 4'd0) begin
                            n_phase = PH_LENGTH;
                        end else if (no != 4'd0) begin
                            n_phase = PH_OFFSET;
                        end else begin
                            // empty run: zero length, zero offset
                            o_push    = 1'b1;
                            o_evt.len = 64'd0;
                            o_evt.off = 64'd0;
                            n_phase   = PH_HEADER;
                        end
                    end
                end
                PH_LENGTH: begin
                    n_len   = len_new;
                    n_pos   = r_pos + 3'd1;
                    n_lleft = lleft_dec;
                    if (lleft_dec == 4'd0) begin
                        if (len_new[63]) begin
                            o_push     = 1'b1;
                            o_evt.kind = KIND_NEG_LENGTH;
                            n_phase    = PH_IDLE;
                        end else if (r_oleft != 4'd0) begin
                            n_phase = PH_OFFSET;
                            n_pos   = 3'd0;
                        end else begin
                            o_push    = 1'b1;
                            o_evt.len = len_new;
                            n_phase   = PH_HEADER;
                        end
                    end
                end
                PH_OFFSET: begin
                    n_oleft = oleft_dec;
                    if (oleft_dec != 4'd0) begin
                        n_off = off_new;
                        n_pos = r_pos + 3'd1;
                    end else begin
                        // last offset byte: sign-extend from its top bit
                        if (i_data_byte[7] && r_pos != 3'd7) begin
                            off_new = off_new | (({64{1'b1}} << 8) << {r_pos, 3'b000});
                        end
                        n_off     = off_new;
                        n_pos     = 3'd0;
                        o_push    = 1'b1;
                        o_evt.off = off_new;
                        n_phase   = PH_HEADER;
                    end
                end
                PH_IDLE: begin
                end
                default: begin
                end
            endcase
            if (o_push) begin
                n_start = 1'b0;
            end
        end
        o_evt.len_m1 = o_evt.len - 64'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_lleft <= 4'd0;
            r_oleft <= 4'd0;
            r_pos   <= 3'd0;
            r_len   <= 64'd0;
            r_off   <= 64'd0;
            r_start <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_lleft <= n_lleft;
            r_oleft <= n_oleft;
            r_pos   <= n_pos;
            r_len   <= n_len;
            r_off   <= n_off;
            r_start <= n_start;
        end
    end

endmodule

`default_nettype wire

### design/crld_queue.sv
// Small FIFO of parsed events between the parser and the cluster unit.
// Depends on crld_pkg.
`default_nettype none

module crld_queue #(
    parameter int DEPTH = crld_pkg::CRLD_Q_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  crld_pkg::t_evt  i_evt,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output crld_pkg::t_evt  o_evt
);
    import crld_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

    t_evt          r_mem [DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_cnt;
    logic          do_push, do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_evt   = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_evt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == LAST) ? '0 : r_wr + PW'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == LAST) ? '0 : r_rd + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

endmodule

`default_nettype wire

### design/crld_back.sv
// Cluster unit: keeps physical/virtual counters, checks limits, drives results.
// Depends on crld_pkg.
`default_nettype none

module crld_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    input  crld_pkg::t_evt     i_evt,
    output logic               o_pop,
    input  logic [63:0]        i_limit,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [2:0]         o_result_kind,
    output logic signed [63:0] o_physical_start,
    output logic [62:0]        o_run_clusters,
    output logic [63:0]        o_virtual_first,
    output logic [63:0]        o_virtual_last
);
    import crld_pkg::*;

    logic        r_dead, r_out_valid;
    logic [63:0] r_phys, r_virt;
    t_kind       r_kind, n_kind;
    logic [63:0] r_ps, r_vf, r_vl, n_ps, n_vf, n_vl;
    logic [62:0] r_rc, n_rc;
    logic [63:0] phys_base, virt_base, phys_sum, last;
    logic        dead, produce, commit, go_dead;

    assign o_pop     = i_q_valid && (!r_out_valid || !i_out_stall);
    assign phys_base = i_evt.start ? 64'd0 : r_phys;
    assign virt_base = i_evt.start ? 64'd0 : r_virt;
    assign dead      = i_evt.start ? 1'b0 : r_dead;
    assign phys_sum  = phys_base + i_evt.off;
    assign last      = virt_base + i_evt.len_m1;

    always_comb begin
        produce = 1'b0;
        commit  = 1'b0;
        go_dead = 1'b0;
        n_kind  = i_evt.kind;
        n_ps    = 64'd0;
        n_rc    = 63'd0;
        n_vf    = 64'd0;
        n_vl    = 64'd0;
        if (!dead) begin
            produce = 1'b1;
            if (i_evt.kind != KIND_RUN) begin
                go_dead = 1'b1;
            end else if (phys_sum[63]) begin
                n_kind  = KIND_NEG_CLUSTER;
                go_dead = 1'b1;
            end else if (last > i_limit) begin
                n_kind  = KIND_LIMIT;
                go_dead = 1'b1;
            end else begin
                commit = 1'b1;
                n_ps   = (i_evt.off == 64'd0) ? {64{1'b1}} : phys_sum;
                n_rc   = i_evt.len[62:0];
                n_vf   = virt_base;
                n_vl   = last;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dead      <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_dead      <= dead || go_dead;
                r_out_valid <= produce;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && commit) begin
            r_phys <= phys_sum;
            r_virt <= virt_base + i_evt.len;
        end
        if (o_pop && produce) begin
            r_kind <= n_kind;
            r_ps   <= n_ps;
            r_rc   <= n_rc;
            r_vf   <= n_vf;
            r_vl   <= n_vl;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_result_kind    = r_kind;
    assign o_physical_start = $signed(r_ps);
    assign o_run_clusters   = r_rc;
    assign o_virtual_first  = r_vf;
    assign o_virtual_last   = r_vl;

endmodule

`default_nettype wire

### design/cluster_run_list_decoder_top.sv
// Cluster run list decoder: one run list byte per cycle in, one result per run out.
// Throughput: one byte per cycle while the event queue has room; results leave at most one per cycle.
// Path: the byte that ends a run pushes its event into the queue; the cluster unit
//   pops it and registers the result, which can wait behind queued events or a stall.
// Reset (i_rst_n low, synchronous): list idle, queue and output empty, limit 0.
// Depends on crld_pkg, crld_front, crld_queue and crld_back.
`default_nettype none

module cluster_run_list_decoder_top #(
    parameter int Q_DEPTH = crld_pkg::CRLD_Q_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // byte input channel
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_list_start,
    input  logic [7:0]         i_data_byte,
    // result channel
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [2:0]         o_result_kind,
    output logic signed [63:0] o_physical_start,
    output logic [62:0]        o_run_clusters,
    output logic [63:0]        o_virtual_first,
    output logic [63:0]        o_virtual_last,
    // limit register write channel
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [63:0]        i_cfg_data
);
    import crld_pkg::*;

    // Front parses bytes into events; the back applies them to the running
    // cluster counters. The front has no view of back-side failures: the back
    // drops events itself after a failure until one tagged with a list start.

    logic [63:0] r_limit;
    logic        push, q_full, q_valid, pop;
    t_evt        front_evt, q_evt;

    // Limit register: always ready, one transfer per cycle.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= 64'd0;
        end else if (i_cfg_valid) begin
            r_limit <= i_cfg_data;
        end
    end

    crld_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_list_start (i_list_start),
        .i_data_byte  (i_data_byte),
        .i_q_full     (q_full),
        .o_push       (push),
        .o_evt        (front_evt)
    );

    // Event queue decouples parser stalls from output stalls.
    crld_queue #(
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_evt   (front_evt),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_evt   (q_evt)
    );

    crld_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_q_valid        (q_valid),
        .i_evt            (q_evt),
        .o_pop            (pop),
        .i_limit          (r_limit),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_result_kind    (o_result_kind),
        .o_physical_start (o_physical_start),
        .o_run_clusters   (o_run_clusters),
        .o_virtual_first  (o_virtual_first),
        .o_virtual_last   (o_virtual_last)
    );

endmodule

`default_nettype wire

### design/crld_checker.sv
// Port-level checker for the cluster run list decoder, bound to the top level.
// Depends on crld_pkg and cluster_run_list_decoder_top_defines.svh.
`default_nettype none
`include "cluster_run_list_decoder_top_defines.svh"

module crld_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic [2:0]         o_result_kind,
    input logic signed [63:0] o_physical_start,
    input logic [62:0]        o_run_clusters,
    input logic [63:0]        o_virtual_first,
    input logic [63:0]        o_virtual_last
);
    import crld_pkg::*;

    // stalled result holds
    `CRLD_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_result_kind) && $stable(o_virtual_last))

    // status results carry zero fields
    `CRLD_ASSERT_IMPL(a_status_zero, o_out_valid && o_result_kind != KIND_RUN, o_physical_start == 64'sd0 && o_run_clusters == 63'd0 && o_virtual_first == 64'd0 && o_virtual_last == 64'd0)

    // run start is either sparse or a non-negative cluster
    `CRLD_ASSERT_IMPL(a_run_phys, o_out_valid && o_result_kind == KIND_RUN, !o_physical_start[63] || (&o_physical_start))

    // last virtual cluster is first plus count minus one
    `CRLD_ASSERT_IMPL(a_run_span, o_out_valid && o_result_kind == KIND_RUN, o_virtual_last == o_virtual_first + {1'b0, o_run_clusters} - 64'd1)

endmodule

bind cluster_run_list_decoder_top crld_checker u_crld_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_out_valid      (o_out_valid),
    .i_out_stall      (i_out_stall),
    .o_result_kind    (o_result_kind),
    .o_physical_start (o_physical_start),
    .o_run_clusters   (o_run_clusters),
    .o_virtual_first  (o_virtual_first),
    .o_virtual_last   (o_virtual_last)
);

`default_nettype wire

### dv/cluster_run_list_decoder_top_test.sv
// Self-checking testbench for cluster_run_list_decoder_top: run list bytes in, run entries out.
// Predicts every result in-line, drives both channels with random idling and a long
// output hold-off. Depends on crld_pkg and the decoder RTL only.
`timescale 1ns / 100ps

module cluster_run_list_decoder_top_test;
    import crld_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    // Parse phases of the predictor's own copy of the decoder state.
    typedef enum logic [1:0] {
        SCAN_IDLE,
        SCAN_HEADER,
        SCAN_LENGTH,
        SCAN_OFFSET
    } scan_phase_t;

    typedef struct packed {
        logic       start;
        logic [7:0] data;
    } list_byte_t;

    typedef struct packed {
        t_kind              kind;
        logic signed [63:0] phys;
        logic [62:0]        clusters;
        logic [63:0]        vcn_first;
        logic [63:0]        vcn_last;
    } run_result_t;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic               i_list_start = 1'b0;
    logic [7:0]         i_data_byte = 8'h00;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic [2:0]         o_result_kind;
    logic signed [63:0] o_physical_start;
    logic [62:0]        o_run_clusters;
    logic [63:0]        o_virtual_first;
    logic [63:0]        o_virtual_last;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [63:0]        i_cfg_data = 64'd0;

    cluster_run_list_decoder_top u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_list_start     (i_list_start),
        .i_data_byte      (i_data_byte),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_result_kind    (o_result_kind),
        .o_physical_start (o_physical_start),
        .o_run_clusters   (o_run_clusters),
        .o_virtual_first  (o_virtual_first),
        .o_virtual_last   (o_virtual_last),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_data       (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Bytes waiting for the driver, and run entries waiting for the monitor.
    list_byte_t  pending_bytes[$];
    run_result_t expected_results[$];

    int unsigned list_bytes = 0;     // bytes queued so far, directed and generated
    int unsigned bytes_taken = 0;    // input transfers so far
    int unsigned mismatch_count = 0;
    int unsigned cycle_count = 0;
    logic        quiet = 1'b0;       // no idling on either side in the closing phase

    // ------------------------------------------------------------------
    // Decoder prediction: own copy of limit and parse state.
    // ------------------------------------------------------------------
    logic [63:0] vcn_limit = 64'd0;
    scan_phase_t scan_phase = SCAN_IDLE;
    logic [3:0]  len_left = 4'd0;
    logic [3:0]  off_left = 4'd0;
    logic [2:0]  byte_pos = 3'd0;
    logic [63:0] len_acc = 64'd0;
    logic [63:0] off_acc = 64'd0;
    logic [63:0] phys_lcn = 64'd0;
    logic [63:0] next_vcn = 64'd0;

    // Any non-run result carries zero fields and closes the list.
    task automatic post_status(input t_kind kind);
        run_result_t r;
        r = '0;
        r.kind = kind;
        expected_results.push_back(r);
        scan_phase = SCAN_IDLE;
    endtask

    task automatic close_run();
        logic [63:0] first_vcn;
        logic [63:0] last_vcn;
        run_result_t r;
        phys_lcn += off_acc;
        if (phys_lcn[63]) begin
            post_status(KIND_NEG_CLUSTER);
        end else begin
            first_vcn = next_vcn;
            next_vcn += len_acc;
            last_vcn = next_vcn - 64'd1;
            if (last_vcn > vcn_limit) begin
                post_status(KIND_LIMIT);
            end else begin
                r.kind      = KIND_RUN;
                r.phys      = (off_acc == 64'd0) ? '1 : phys_lcn;  // sparse run
                r.clusters  = len_acc[62:0];
                r.vcn_first = first_vcn;
                r.vcn_last  = last_vcn;
                expected_results.push_back(r);
                scan_phase = SCAN_HEADER;
            end
        end
    endtask

    task automatic end_of_length();
        if (len_acc[63]) begin
            post_status(KIND_NEG_LENGTH);
        end else if (off_left != 4'd0) begin
            scan_phase = SCAN_OFFSET;
            byte_pos = 3'd0;
        end else begin
            close_run();
        end
    endtask

    task automatic decode_byte(input logic start, input logic [7:0] b);
        if (start) begin
            phys_lcn = 64'd0;
            next_vcn = 64'd0;
            scan_phase = SCAN_HEADER;
        end
        case (scan_phase)
            SCAN_HEADER: begin
                if (b == 8'h00) begin
                    post_status(KIND_END_OK);
                end else if (b[3:0] > CRLD_MAX_FIELD_BYTES || b[7:4] > CRLD_MAX_FIELD_BYTES) begin
                    post_status(KIND_BAD_HEADER);
                end else begin
                    len_left = b[3:0];
                    off_left = b[7:4];
                    byte_pos = 3'd0;
                    len_acc = 64'd0;
                    off_acc = 64'd0;
                    if (b[3:0] != 4'd0) scan_phase = SCAN_LENGTH;
                    else end_of_length();
                end
            end
            SCAN_LENGTH: begin
                len_acc |= 64'(b) << (8 * int'(byte_pos));
                byte_pos = byte_pos + 3'd1;
                len_left = len_left - 4'd1;
                if (len_left == 4'd0) end_of_length();
            end
            SCAN_OFFSET: begin
                off_acc |= 64'(b) << (8 * int'(byte_pos));
                off_left = off_left - 4'd1;
                if (off_left != 4'd0) begin
                    byte_pos = byte_pos + 3'd1;
                end else begin
                    // sign-extend from the top bit of the last offset byte
                    if (b[7] && byte_pos < 3'd7)
                        off_acc |= ~64'd0 << (8 * (int'(byte_pos) + 1));
                    byte_pos = 3'd0;
                    close_run();
                end
            end
            default: ;  // list ended, byte ignored
        endcase
    endtask

    // ------------------------------------------------------------------
    // Stimulus builders
    // ------------------------------------------------------------------
    task automatic add_byte(input logic start, input logic [7:0] data);
        list_byte_t lb;
        lb.start = start;
        lb.data = data;
        pending_bytes.push_back(lb);
        list_bytes++;
    endtask

    // One run: header, length bytes, offset bytes. Mostly well formed.
    task automatic add_run(input logic start);
        int nl;
        int no;
        int pick;
        logic [7:0] b;
        pick = $urandom_range(0, 99);
        if (pick < 8) nl = 0;
        else if (pick < 75) nl = $urandom_range(1, 2);
        else nl = $urandom_range(3, 8);
        pick = $urandom_range(0, 99);
        if (pick < 15) no = 0;
        else if (pick < 80) no = $urandom_range(1, 3);
        else no = $urandom_range(4, 8);
        if ($urandom_range(0, 39) == 0) begin
            if ($urandom_range(0, 1) == 1) nl = $urandom_range(9, 15);
            else no = $urandom_range(9, 15);
        end
        add_byte(start, {4'(no), 4'(nl)});
        if (nl > 8 || no > 8) return;
        for (int i = 0; i < nl; i++) begin
            b = 8'($urandom);
            // long lengths mostly kept positive
            if (i == nl - 1 && nl > 2 && $urandom_range(0, 9) != 0) b[7] = 1'b0;
            add_byte(1'b0, b);
        end
        for (int i = 0; i < no; i++) begin
            b = 8'($urandom);
            // most offsets move forward so the list gets past its first runs
            if (i == no - 1 && $urandom_range(0, 4) != 0) b[7] = 1'b0;
            add_byte(1'b0, b);
        end
    endtask

    task automatic add_random_list();
        int runs;
        runs = $urandom_range(1, 8);
        for (int r = 0; r < runs; r++) add_run(r == 0);
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: add_byte(1'b0, 8'h00);
            6: repeat ($urandom_range(1, 3)) add_byte(1'b0, 8'($urandom));
            7: begin
                // partial run, cut off by the next start
                add_byte(1'b0, 8'h33);
                add_byte(1'b0, 8'($urandom));
            end
            default: ;
        endcase
        if ($urandom_range(0, 4) == 0) add_byte(1'b0, 8'($urandom));
    endtask

    task automatic add_random_phase(input int unsigned n_bytes);
        int unsigned target;
        target = list_bytes + n_bytes;
        while (list_bytes < target) add_random_list();
    endtask

    // Wait until every byte is taken and every result has arrived, then let the pipe drain.
    task automatic settle();
        do @(posedge i_clk);
        while (pending_bytes.size() != 0 || i_in_valid || expected_results.size() != 0);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [63:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        vcn_limit = value;
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Limit still at its reset value of zero.
        add_byte(1'b0, 8'h31);                      // idle byte, ignored
        add_byte(1'b1, 8'h11); add_byte(1'b0, 8'h01); add_byte(1'b0, 8'h05);
        add_byte(1'b0, 8'h00);                      // clean end
        add_byte(1'b1, 8'h11); add_byte(1'b0, 8'h02); // abandoned by next start
        add_byte(1'b1, 8'h11); add_byte(1'b0, 8'h02); add_byte(1'b0, 8'h01); // over limit
        add_byte(1'b1, 8'h19);                      // length nibble above eight
        add_byte(1'b1, 8'h91);                      // offset nibble above eight
        settle();

        write_limit('1);
        add_byte(1'b1, 8'h08);                      // eight length bytes, top bit set
        repeat (8) add_byte(1'b0, 8'hFF);
        add_byte(1'b1, 8'h11); add_byte(1'b0, 8'h01); add_byte(1'b0, 8'hFF); // below cluster 0
        add_byte(1'b1, 8'h10); add_byte(1'b0, 8'h05); // zero length, last wraps
        add_byte(1'b0, 8'h01); add_byte(1'b0, 8'h03); // sparse run
        add_byte(1'b0, 8'h00);
        settle();

        write_limit('1);
        add_random_phase(300);
        settle();
        write_limit({32'($urandom), 32'($urandom)});
        add_random_phase(300);
        settle();
        write_limit(64'h7FFF_FFFF_FFFF_FFFF);
        add_random_phase(300);
        settle();
        write_limit(64'($urandom_range(0, 5000)));
        add_random_phase(250);
        settle();
        write_limit(64'd0);
        add_random_phase(150);
        settle();

        // Closing phase at full rate on both sides.
        quiet = 1'b1;
        write_limit('1);
        add_random_phase(300);
        settle();

        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // Byte driver: predicts on each transfer, then loads the next byte.
    // ------------------------------------------------------------------
    int unsigned send_gap = 0;

    always @(posedge i_clk) begin : byte_driver
        list_byte_t nxt;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                decode_byte(i_list_start, i_data_byte);
                bytes_taken++;
            end
            // a stalled byte stays on the port unchanged
            if (!i_in_valid || !o_in_stall) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_in_valid <= 1'b0;
                end else if (pending_bytes.size() == 0) begin
                    i_in_valid <= 1'b0;
                end else if (!quiet && $urandom_range(0, 15) == 0) begin
                    send_gap = $urandom_range(0, 13);
                    i_in_valid <= 1'b0;
                end else begin
                    nxt = pending_bytes.pop_front();
                    i_list_start <= nxt.start;
                    i_data_byte <= nxt.data;
                    i_in_valid <= 1'b1;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result receiver: random stall bursts plus a long hold-off every
    // 700 input transfers, long enough to back the block up into its input.
    // ------------------------------------------------------------------
    int unsigned stall_left = 0;
    int unsigned hold_left = 0;
    int unsigned next_hold_at = 300;

    always @(posedge i_clk) begin : result_receiver
        if (i_rst_n) begin
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else if (!quiet && bytes_taken >= next_hold_at) begin
                hold_left = 299;
                next_hold_at += 700;
                i_out_stall <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                i_out_stall <= 1'b1;
            end else if (!quiet && $urandom_range(0, 11) == 0) begin
                stall_left = $urandom_range(0, 13);
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: each transfer against the oldest expectation.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : result_monitor
        run_result_t want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: kind %0d phys %0d clusters %0d vcn %0h..%0h",
                             o_result_kind, o_physical_start, o_run_clusters,
                             o_virtual_first, o_virtual_last);
            end else begin
                want = expected_results.pop_front();
                if (o_result_kind !== want.kind || o_physical_start !== want.phys ||
                    o_run_clusters !== want.clusters || o_virtual_first !== want.vcn_first ||
                    o_virtual_last !== want.vcn_last) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("mismatch: expected kind %0d phys %0d clusters %0d vcn %0h..%0h",
                                 want.kind, want.phys, want.clusters,
                                 want.vcn_first, want.vcn_last);
                        $display("          actual   kind %0d phys %0d clusters %0d vcn %0h..%0h",
                                 o_result_kind, o_physical_start, o_run_clusters,
                                 o_virtual_first, o_virtual_last);
                    end
                end
            end
        end
    end

    // Hang guard.
    always @(posedge i_clk) begin : watchdog
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

endmodule

### sim.f
+incdir+design
design/crld_pkg.sv
design/crld_front.sv
design/crld_queue.sv
design/crld_back.sv
design/cluster_run_list_decoder_top.sv
design/crld_checker.sv
dv/cluster_run_list_decoder_top_test.sv
